[rtl/hlfp_pkg.sv]
package hlfp_pkg;

	// frame layout
	localparam int unsigned PAYLOAD_CAPTURE = 7;
	localparam int unsigned COUNT_W = $clog2(PAYLOAD_CAPTURE + 1);
	localparam logic [7:0] SYNC_BYTE = 8'h7E;
	localparam logic [7:0] LINKQ_KIND = 8'hFE;

	// result status codes
	localparam logic [1:0] STATUS_LINKQ = 2'd0;
	localparam logic [1:0] STATUS_OTHER = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	// one result beat
	typedef struct packed {
		logic [1:0] frame_status;
		logic [7:0] analog_one;
		logic [7:0] analog_two;
		logic [7:0] link_quality;
	} hlfp_result_t;

endpackage

[rtl/hlfp_parse_core.sv]
module hlfp_parse_core
	import hlfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	output logic         res_valid,
	output hlfp_result_t res
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_KIND    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_TRAILER = 2'd3;

	logic [1:0]         phase_q;
	logic [1:0]         phase_d;
	logic [COUNT_W-1:0] count_q;
	logic [7:0]         kind_q;
	logic [7:0]         cap_q [3];
	logic [7:0]         latch_q [3];
	logic               good_linkq;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == SYNC_BYTE) phase_d = PH_KIND;
			end
			PH_KIND: begin
				if (rx_byte != SYNC_BYTE) phase_d = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (count_q == COUNT_W'(PAYLOAD_CAPTURE)) phase_d = PH_TRAILER;
			end
			PH_TRAILER: begin
				phase_d = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	assign good_linkq = (phase_q == PH_TRAILER) && (rx_byte == SYNC_BYTE)
		&& (kind_q == LINKQ_KIND);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			kind_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == PH_KIND && rx_byte != SYNC_BYTE) begin
				kind_q  <= rx_byte;
				count_q <= '0;
			end else if (phase_q == PH_PAYLOAD && count_q != COUNT_W'(PAYLOAD_CAPTURE)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	// first three payload bytes, no reset
	always_ff @(posedge clk) begin
		if (step && phase_q == PH_PAYLOAD && count_q < COUNT_W'(3)) begin
			cap_q[count_q[1:0]] <= rx_byte;
		end
	end

	// latched readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q[0] <= '0;
			latch_q[1] <= '0;
			latch_q[2] <= '0;
		end else if (step && good_linkq) begin
			latch_q[0] <= cap_q[0];
			latch_q[1] <= cap_q[1];
			latch_q[2] <= cap_q[2];
		end
	end

	// result for a trailer byte
	assign res_valid = (phase_q == PH_TRAILER);

	always_comb begin
		if (rx_byte != SYNC_BYTE) begin
			res.frame_status = STATUS_ERROR;
		end else if (kind_q == LINKQ_KIND) begin
			res.frame_status = STATUS_LINKQ;
		end else begin
			res.frame_status = STATUS_OTHER;
		end
		res.analog_one   = good_linkq ? cap_q[0] : latch_q[0];
		res.analog_two   = good_linkq ? cap_q[1] : latch_q[1];
		res.link_quality = good_linkq ? cap_q[2] : latch_q[2];
	end

	a_trailer_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_TRAILER |=> phase_q == PH_HUNT)
		else $error("parser did not return to hunting after trailer");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(latch_q[2]) && $stable(count_q))
		else $error("parser state moved without a beat");

	a_payload_stays: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_PAYLOAD && count_q != COUNT_W'(PAYLOAD_CAPTURE)
		|=> phase_q == PH_PAYLOAD)
		else $error("payload phase left early");

	a_latch_only_good: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && good_linkq) |=> $stable(latch_q[0]) && $stable(latch_q[1]))
		else $error("readings changed without a good link quality frame");

endmodule

[rtl/host_link_frame_parser.sv]
// host link frame parser
// input channel: one received byte per beat on rx_byte, in_valid / in_ready
// output channel: one result beat per trailer byte on frame_status and the
//   three latched readings, out_valid / out_ready
// bytes that are not trailers produce no output beat
// a byte is held in an input register, then parsed in a single pass and the
// result, if any, goes into an output register
// throughput: one byte per cycle while no trailer byte is stalled, set by the single parse pass
// while a result waits in the output register, bytes that give no result
// still flow; a trailer byte waits in the input register until the output
// register is taken or freed, and in_ready drops only then
// reset clears both valid flags, the parse phase, the frame type and the
// latched readings, and the parser starts hunting for the sync byte
module host_link_frame_parser
	import hlfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] frame_status,
	output logic [7:0] analog_one,
	output logic [7:0] analog_two,
	output logic [7:0] link_quality
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         out_valid_q;
	hlfp_result_t res_q;
	logic         core_res_valid;
	hlfp_result_t core_res;
	logic         stall;
	logic         step;

	// hold the byte when its result cannot be stored
	assign stall    = valid_s1 && core_res_valid && out_valid_q && !out_ready;
	assign step     = valid_s1 && !stall;
	assign in_ready = !stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	hlfp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.res_valid (core_res_valid),
		.res       (core_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && core_res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && core_res_valid) begin
			res_q <= core_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = res_q.frame_status;
	assign analog_one   = res_q.analog_one;
	assign analog_two   = res_q.analog_two;
	assign link_quality = res_q.link_quality;

endmodule

[tb/sv/frame_parser_checker.sv]
`timescale 1ns / 100ps

module frame_parser_checker
	import hlfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] frame_status,
	input  logic [7:0] analog_one,
	input  logic [7:0] analog_two,
	input  logic [7:0] link_quality,
	output int         mismatch_total,
	output int         frames_pending
);

	typedef enum logic [1:0] {
		SEEK_SYNC,
		TAKE_KIND,
		TAKE_PAYLOAD,
		AWAIT_TRAILER
	} parse_phase_e;

	// shadow parser state
	parse_phase_e       phase;
	logic [COUNT_W-1:0] payload_seen;
	logic [7:0]         kind;
	logic [7:0]         captured [3];
	logic [7:0]         latched [3];

	hlfp_result_t expected_frames [$];
	int           errors;

	assign mismatch_total = errors;

	// walk one byte through the shadow parser, queue a result on a trailer
	task automatic parse_byte(input logic [7:0] b);
		hlfp_result_t res;
		case (phase)
			SEEK_SYNC: begin
				if (b == SYNC_BYTE)
					phase = TAKE_KIND;
			end
			TAKE_KIND: begin
				// further sync bytes are ignored here
				if (b != SYNC_BYTE) begin
					kind = b;
					payload_seen = '0;
					phase = TAKE_PAYLOAD;
				end
			end
			TAKE_PAYLOAD: begin
				// the byte after the last payload byte is dropped
				if (payload_seen < COUNT_W'(PAYLOAD_CAPTURE)) begin
					if (payload_seen < COUNT_W'(3))
						captured[payload_seen[1:0]] = b;
					payload_seen = payload_seen + 1'b1;
				end else begin
					phase = AWAIT_TRAILER;
				end
			end
			default: begin
				phase = SEEK_SYNC;
				if (b == SYNC_BYTE) begin
					if (kind == LINKQ_KIND) begin
						latched = captured;
						res.frame_status = STATUS_LINKQ;
					end else begin
						res.frame_status = STATUS_OTHER;
					end
				end else begin
					res.frame_status = STATUS_ERROR;
				end
				res.analog_one = latched[0];
				res.analog_two = latched[1];
				res.link_quality = latched[2];
				expected_frames.push_back(res);
			end
		endcase
	endtask

	function automatic int field_miss(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// result beats are checked before this edge's byte is predicted
	always @(posedge clk or negedge arst_n) begin
		hlfp_result_t want;
		if (!arst_n) begin
			phase = SEEK_SYNC;
			payload_seen = '0;
			kind = '0;
			captured = '{default: 8'h00};
			latched = '{default: 8'h00};
			expected_frames.delete();
			frames_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					$error("result beat with no frame pending");
					errors++;
				end else begin
					want = expected_frames.pop_front();
					errors += field_miss("frame_status",
						32'(want.frame_status), 32'(frame_status));
					errors += field_miss("analog_one",
						32'(want.analog_one), 32'(analog_one));
					errors += field_miss("analog_two",
						32'(want.analog_two), 32'(analog_two));
					errors += field_miss("link_quality",
						32'(want.link_quality), 32'(link_quality));
				end
			end
			if (in_valid && in_ready)
				parse_byte(rx_byte);
			frames_pending <= expected_frames.size();
		end
	end

	initial errors = 0;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench
	import hlfp_pkg::*;
();

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] frame_status;
	logic [7:0] analog_one;
	logic [7:0] analog_two;
	logic [7:0] link_quality;

	int mismatch_total;
	int frames_pending;

	int send_idle = 31;
	int recv_idle = 70;
	int bytes_sent = 0;
	bit want_hold = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	host_link_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_status(frame_status),
		.analog_one(analog_one),
		.analog_two(analog_two),
		.link_quality(link_quality)
	);

	frame_parser_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_status(frame_status),
		.analog_one(analog_one),
		.analog_two(analog_two),
		.link_quality(link_quality),
		.mismatch_total(mismatch_total),
		.frames_pending(frames_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (want_hold && !hold_done) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// offer one byte, with a random gap in front of it
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	// one frame with random content, sometimes cut short or badly terminated
	task automatic send_frame();
		int payload_len;
		if ($urandom_range(3) == 0)
			send_byte(8'($urandom_range(255)));
		send_byte(SYNC_BYTE);
		if ($urandom_range(3) == 0)
			send_byte(SYNC_BYTE);
		send_byte($urandom_range(1) ? LINKQ_KIND : 8'($urandom_range(255)));
		payload_len = ($urandom_range(9) == 0) ? $urandom_range(PAYLOAD_CAPTURE - 1) :
			PAYLOAD_CAPTURE;
		repeat (payload_len) send_byte(8'($urandom_range(255)));
		if (payload_len < PAYLOAD_CAPTURE)
			return;
		send_byte(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom_range(255)));
		send_byte(($urandom_range(99) < 80) ? SYNC_BYTE : 8'($urandom_range(255)));
	endtask

	// mostly frames, some runs of noise
	task automatic random_traffic(input int n_bytes);
		int target;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			if ($urandom_range(99) < 85)
				send_frame();
			else
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
		end
	endtask

	logic [7:0] directed_bytes [24] = '{
		// noise while hunting, repeated sync, link quality frame, 0x7E as skipped byte
		8'h00, 8'h7E, 8'h7E, 8'hFE, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h7E, 8'h12, 8'h34,
		8'h7E, 8'h7E,
		// link quality frame with a bad trailer, readings must stay
		8'h7E, 8'hFE, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'hFF
	};

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		send_idle = 31;
		recv_idle = 70;
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		random_traffic(130);

		// roles swapped
		send_idle = 70;
		recv_idle = 31;
		random_traffic(135);

		// no idling, with one long receiver hold-off to fill the block
		send_idle = 0;
		recv_idle = 0;
		want_hold = 1'b1;
		random_traffic(135);
		in_valid <= 1'b0;

		// drain and settle
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_total == 0 && frames_pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[host_link_frame_parser.f]
rtl/hlfp_pkg.sv
rtl/hlfp_parse_core.sv
rtl/host_link_frame_parser.sv
tb/sv/frame_parser_checker.sv
tb/sv/testbench.sv
